@@ hw/rtl/tcs_pkg.sv @@
package tcs_pkg;

	// Field widths that the interface fixes.
	localparam int POS_W  = 10;
	localparam int IPOS_W = 9;
	localparam int SW     = 11;
	localparam int DIM_W  = 9;
	localparam int CELL_W = 24;

	// Defaults for the store geometry.
	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 64;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] SPACE_CODE = 8'h20;

	// Register reset values.
	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET    = 7'd30;
	localparam logic [7:0] FORE_RESET    = 8'd212;
	localparam logic [7:0] BACK_RESET    = 8'd192;

	// Register indexes.
	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_FORE    = 2'd2;
	localparam logic [1:0] REG_BACK    = 2'd3;

	// Operation codes on the request port.
	localparam logic [3:0] OP_WRITE     = 4'd0;
	localparam logic [3:0] OP_LEFT      = 4'd1;
	localparam logic [3:0] OP_RIGHT     = 4'd2;
	localparam logic [3:0] OP_DOWN      = 4'd3;
	localparam logic [3:0] OP_UP        = 4'd4;
	localparam logic [3:0] OP_HOME      = 4'd5;
	localparam logic [3:0] OP_LINESTART = 4'd6;
	localparam logic [3:0] OP_BACKSPACE = 4'd7;
	localparam logic [3:0] OP_CLEAR     = 4'd8;
	localparam logic [3:0] OP_SETPOS    = 4'd9;
	localparam logic [3:0] OP_READ      = 4'd10;

	typedef enum logic [3:0] {
		CMD_WRITE,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_DOWN,
		CMD_UP,
		CMD_HOME,
		CMD_LINESTART,
		CMD_BACKSPACE,
		CMD_CLEAR,
		CMD_SETPOS,
		CMD_READ,
		CMD_NOP
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              scroll;
		logic [7:0]        ch;
		logic [IPOS_W-1:0] pc;
		logic [IPOS_W-1:0] pr;
	} item_t;

	// Effective screen geometry and colours.
	typedef struct packed {
		logic [DIM_W-1:0] cols;
		logic [DIM_W-1:0] rows;
		logic [7:0]       fore;
		logic [7:0]       back;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN,
		ST_EXEC,
		ST_LOOK,
		ST_RESP
	} state_t;

endpackage

@@ hw/rtl/text_cell_cursor_scroll_engine_core.sv @@
// Character-cell text screen with a signed cursor and a scroll unit. After reset the
// block clears the whole cell store, one cell per cycle, and takes no request until
// that pass is done; register writes are taken throughout. A cursor command with the
// cursor on screen passes through the check, execute, look-up and response states once
// its request is taken, when the executor is idle and the output register free;
// when the cursor must be brought back into view, each scroll direction adds one walk
// over the screen through the single write and single read port of the cell store.
// Clear adds one fill walk over the screen. Requests queue two deep ahead of the
// executor, and a finished result waits in its own output register.
module text_cell_cursor_scroll_engine_core import tcs_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        op,
	input  logic [7:0]        char_code,
	input  logic [IPOS_W-1:0] pos_column,
	input  logic [IPOS_W-1:0] pos_row,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        cell_char,
	output logic [7:0]        cell_fore,
	output logic [7:0]        cell_back,
	output logic [POS_W-1:0]  cursor_column,
	output logic [POS_W-1:0]  cursor_row,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	logic  q_push, q_pop, q_full, q_empty, init_busy;
	item_t push_item, pop_item;
	cfg_t  cfg;

	tcs_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .op, .char_code, .pos_column, .pos_row,
		.cfg_wr_en, .cfg_index, .cfg_data, .q_full, .init_busy,
		.q_push, .q_item(push_item), .cfg
	);

	tcs_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_item, .pop(q_pop), .pop_item,
		.full(q_full), .empty(q_empty)
	);

	tcs_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk, .arst_n, .cfg, .q_item(pop_item), .q_empty, .q_pop, .init_busy,
		.out_valid, .out_ready, .cell_char, .cell_fore, .cell_back,
		.cursor_column, .cursor_row
	);

endmodule

@@ hw/rtl/tcs_front.sv @@
module tcs_front import tcs_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        op,
	input  logic [7:0]        char_code,
	input  logic [IPOS_W-1:0] pos_column,
	input  logic [IPOS_W-1:0] pos_row,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              q_full,
	input  logic              init_busy,
	output logic              q_push,
	output item_t             q_item,
	output cfg_t              cfg
);

	logic [7:0] cols_q;
	logic [6:0] rows_q;
	logic [7:0] fore_q;
	logic [7:0] back_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
			fore_q <= FORE_RESET;
			back_q <= BACK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COLUMNS: cols_q <= cfg_data;
				REG_ROWS:    rows_q <= cfg_data[6:0];
				REG_FORE:    fore_q <= cfg_data;
				REG_BACK:    back_q <= cfg_data;
			endcase
		end
	end

	// Clamp the screen size into the store.
	always_comb begin
		cfg.fore = fore_q;
		cfg.back = back_q;
		if (cols_q == 8'd0) begin
			cfg.cols = DIM_W'(1);
		end else if (DIM_W'(cols_q) > DIM_W'(MAX_COLUMNS)) begin
			cfg.cols = DIM_W'(MAX_COLUMNS);
		end else begin
			cfg.cols = DIM_W'(cols_q);
		end
		if (rows_q == 7'd0) begin
			cfg.rows = DIM_W'(1);
		end else if (DIM_W'(rows_q) > DIM_W'(MAX_ROWS)) begin
			cfg.rows = DIM_W'(MAX_ROWS);
		end else begin
			cfg.rows = DIM_W'(rows_q);
		end
	end

	// Accept a request and classify its operation.
	assign in_ready = !q_full && !init_busy;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_item.ch = char_code;
		q_item.pc = pos_column;
		q_item.pr = pos_row;
		unique case (op)
			OP_WRITE:     q_item.cmd = CMD_WRITE;
			OP_LEFT:      q_item.cmd = CMD_LEFT;
			OP_RIGHT:     q_item.cmd = CMD_RIGHT;
			OP_DOWN:      q_item.cmd = CMD_DOWN;
			OP_UP:        q_item.cmd = CMD_UP;
			OP_HOME:      q_item.cmd = CMD_HOME;
			OP_LINESTART: q_item.cmd = CMD_LINESTART;
			OP_BACKSPACE: q_item.cmd = CMD_BACKSPACE;
			OP_CLEAR:     q_item.cmd = CMD_CLEAR;
			OP_SETPOS:    q_item.cmd = CMD_SETPOS;
			OP_READ:      q_item.cmd = CMD_READ;
			default:      q_item.cmd = CMD_NOP;
		endcase
		// Cursor commands first bring the cursor back into view.
		q_item.scroll = (op <= OP_BACKSPACE);
	end

endmodule

@@ hw/rtl/tcs_queue.sv @@
module tcs_queue import tcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	item_t         slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [NW-1:0] count_q;

	assign full     = (count_q == NW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = slot_q[rptr_q];

	// Pointer and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

endmodule

@@ hw/rtl/tcs_back.sv @@
module tcs_back import tcs_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  item_t            q_item,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             init_busy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_fore,
	output logic [7:0]       cell_back,
	output logic [POS_W-1:0] cursor_column,
	output logic [POS_W-1:0] cursor_row
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	state_t state_q, state_d;

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_q;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_wa, mem_ra;
	logic [CELL_W-1:0] mem_wd;

	logic [POS_W-1:0]  col_q, row_q;
	item_t             item_q;
	logic [AW-1:0]     init_q;
	logic [CIW-1:0]    wc_q;
	logic [RIW-1:0]    wr_q;
	logic signed [SW-1:0] delta_q;
	logic              desc_q, horiz_q, fill_q;
	logic              wv_s1, wb_s1;
	logic [AW-1:0]     wa_s1;
	logic              hit_q;

	logic signed [SW-1:0] cols_s, rows_s, col_s, row_s, wc_s, wr_s;
	logic signed [SW-1:0] coord, dim, src;
	logic signed [SW-1:0] nh, nv, nc, nr, rp_c, rp_r;
	logic              blank, walk_last, hneg, hpos, vneg, vpos, hit;
	logic [CIW-1:0]    src_c;
	logic [RIW-1:0]    src_r;
	logic              exec_we;
	logic [CELL_W-1:0] exec_wd, blank_cell;
	logic signed [SW-1:0] ex_c, ex_r;

	function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] r,
	                                            input logic [CIW-1:0] c);
		return AW'(32'(r) * MAX_COLUMNS + 32'(c));
	endfunction

	assign blank_cell = {cfg.back, cfg.fore, SPACE_CODE};
	assign init_busy  = (state_q == ST_INIT);

	// Signed views of geometry and cursor.
	assign cols_s = $signed(SW'(cfg.cols));
	assign rows_s = $signed(SW'(cfg.rows));
	assign col_s  = SW'($signed(col_q));
	assign row_s  = SW'($signed(row_q));
	assign wc_s   = $signed(SW'(wc_q));
	assign wr_s   = $signed(SW'(wr_q));

	// Cursor position against the screen, with saturated scroll distances.
	assign hneg = (col_s < 0);
	assign hpos = (col_s >= cols_s);
	assign vneg = (row_s < 0);
	assign vpos = (row_s >= rows_s);

	always_comb begin
		nh = hneg ? -col_s : col_s - cols_s + SW'(1);
		if (nh > cols_s) begin
			nh = cols_s;
		end
		nv = vneg ? -row_s : row_s - rows_s + SW'(1);
		if (nv > rows_s) begin
			nv = rows_s;
		end
	end

	// Source of the cell being walked; outside the screen, or a fill walk, means blank.
	always_comb begin
		coord = horiz_q ? wc_s : wr_s;
		dim   = horiz_q ? cols_s : rows_s;
		src   = coord + delta_q;
		blank = fill_q || (src < 0) || (src >= dim);
		src_c = horiz_q ? src[CIW-1:0] : wc_q;
		src_r = horiz_q ? wr_q : src[RIW-1:0];
		if (desc_q) begin
			walk_last = (wc_q == '0) && (wr_q == '0);
		end else begin
			walk_last = (wc_s == cols_s - SW'(1)) && (wr_s == rows_s - SW'(1));
		end
	end

	// Cursor command execution.
	always_comb begin
		nc      = col_s;
		nr      = row_s;
		ex_c    = col_s;
		ex_r    = row_s;
		exec_we = 1'b0;
		exec_wd = blank_cell;
		unique case (item_q.cmd)
			CMD_WRITE: begin
				exec_we = 1'b1;
				exec_wd = {cfg.back, cfg.fore, item_q.ch};
				nc = col_s + SW'(1);
				if (nc >= cols_s) begin
					nc = '0;
					nr = row_s + SW'(1);
				end
			end
			CMD_LEFT, CMD_BACKSPACE: begin
				if (col_s > 0) begin
					nc = col_s - SW'(1);
					exec_we = (item_q.cmd == CMD_BACKSPACE);
				end else if (row_s > 0) begin
					nr = row_s - SW'(1);
					nc = cols_s - SW'(1);
					exec_we = (item_q.cmd == CMD_BACKSPACE);
				end
				ex_c = nc;
				ex_r = nr;
			end
			CMD_RIGHT: begin
				if (col_s < cols_s - SW'(1)) begin
					nc = col_s + SW'(1);
				end else if (row_s < rows_s - SW'(1)) begin
					nr = row_s + SW'(1);
					nc = '0;
				end
			end
			CMD_DOWN: nr = row_s + SW'(1);
			CMD_UP: begin
				if (row_s > 0) begin
					nr = row_s - SW'(1);
				end
			end
			CMD_HOME, CMD_CLEAR: begin
				nc = '0;
				nr = '0;
			end
			CMD_LINESTART: nc = '0;
			CMD_SETPOS: begin
				nc = SW'($signed(item_q.pc));
				nr = SW'($signed(item_q.pr));
			end
			default: begin
			end
		endcase
	end

	// Position reported with the result.
	always_comb begin
		if (item_q.cmd == CMD_READ) begin
			rp_c = SW'($signed(item_q.pc));
			rp_r = SW'($signed(item_q.pr));
		end else begin
			rp_c = col_s;
			rp_r = row_s;
		end
		hit = (rp_c >= 0) && (rp_r >= 0) && (rp_c < cols_s) && (rp_r < rows_s);
	end

	// Cell store port control.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cell_addr(ex_r[RIW-1:0], ex_c[CIW-1:0]);
		mem_wd = exec_wd;
		if (state_q == ST_INIT) begin
			mem_we = 1'b1;
			mem_wa = init_q;
			mem_wd = '0;
		end else if (wv_s1) begin
			mem_we = 1'b1;
			mem_wa = wa_s1;
			mem_wd = wb_s1 ? blank_cell : rd_q;
		end else if (state_q == ST_EXEC) begin
			mem_we = exec_we;
		end
		mem_re = 1'b0;
		mem_ra = cell_addr(src_r, src_c);
		if (state_q == ST_WALK) begin
			mem_re = !blank;
		end else if (state_q == ST_LOOK) begin
			mem_re = 1'b1;
			mem_ra = cell_addr(rp_r[RIW-1:0], rp_c[CIW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (item_q.scroll && (hneg || hpos || vneg || vpos)) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_WALK: begin
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = fill_q ? ST_LOOK : ST_CHECK;
			ST_EXEC:  state_d = (item_q.cmd == CMD_CLEAR) ? ST_WALK : ST_LOOK;
			ST_LOOK:  state_d = ST_RESP;
			ST_RESP: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Cursor, walk sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			init_q    <= '0;
			wv_s1     <= 1'b0;
			out_valid <= 1'b0;
			fill_q    <= 1'b0;
		end else begin
			wv_s1 <= (state_q == ST_WALK);
			if (out_valid && out_ready && state_q != ST_RESP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: init_q <= init_q + 1'b1;
				ST_IDLE: fill_q <= 1'b0;
				ST_CHECK: begin
					// Horizontal scroll goes first, then vertical. The cursor only
					// moves when the command scrolls.
					if (hneg || hpos) begin
						horiz_q <= 1'b1;
						desc_q  <= hneg;
						delta_q <= hneg ? -nh : nh;
						if (item_q.scroll) begin
							col_q <= hneg ? '0 : POS_W'(cols_s - SW'(1));
						end
					end else begin
						horiz_q <= 1'b0;
						desc_q  <= vneg;
						delta_q <= vneg ? -nv : nv;
						if (item_q.scroll && (vneg || vpos)) begin
							row_q <= vneg ? '0 : POS_W'(rows_s - SW'(1));
						end
					end
					if (hneg || (!hpos && vneg)) begin
						wc_q <= CIW'(cols_s - SW'(1));
						wr_q <= RIW'(rows_s - SW'(1));
					end else begin
						wc_q <= '0;
						wr_q <= '0;
					end
				end
				ST_WALK: begin
					if (desc_q) begin
						if (wc_q == '0) begin
							wc_q <= CIW'(cols_s - SW'(1));
							wr_q <= wr_q - 1'b1;
						end else begin
							wc_q <= wc_q - 1'b1;
						end
					end else begin
						if (wc_s == cols_s - SW'(1)) begin
							wc_q <= '0;
							wr_q <= wr_q + 1'b1;
						end else begin
							wc_q <= wc_q + 1'b1;
						end
					end
				end
				ST_EXEC: begin
					col_q   <= POS_W'(nc);
					row_q   <= POS_W'(nr);
					fill_q  <= 1'b1;
					horiz_q <= 1'b1;
					desc_q  <= 1'b0;
					delta_q <= '0;
					wc_q    <= '0;
					wr_q    <= '0;
				end
				ST_LOOK: hit_q <= hit;
				ST_RESP: begin
					if (!out_valid || out_ready) begin
						out_valid     <= 1'b1;
						cell_char     <= hit_q ? rd_q[7:0] : 8'd0;
						cell_fore     <= hit_q ? rd_q[15:8] : 8'd0;
						cell_back     <= hit_q ? rd_q[23:16] : 8'd0;
						cursor_column <= col_q;
						cursor_row    <= row_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item register and the write stage of the walk.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		wa_s1 <= cell_addr(wr_q, wc_q);
		wb_s1 <= blank;
	end

endmodule

@@ verif/tb_checker.sv @@
// Watches the request, result and register ports of the text screen, keeps its own copy
// of the cell store and cursor, and compares every result with the predicted one.
module tb_checker import tcs_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [3:0]        op,
	input  logic [7:0]        char_code,
	input  logic [IPOS_W-1:0] pos_column,
	input  logic [IPOS_W-1:0] pos_row,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        cell_char,
	input  logic [7:0]        cell_fore,
	input  logic [7:0]        cell_back,
	input  logic [POS_W-1:0]  cursor_column,
	input  logic [POS_W-1:0]  cursor_row,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0]       ch;
		logic [7:0]       fore;
		logic [7:0]       back;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} screen_view_t;

	logic [CELL_W-1:0] screen_mem [MAX_ROWS*MAX_COLUMNS];
	int                ccol;
	int                crow;
	logic [7:0]        reg_cols;
	logic [6:0]        reg_rows;
	logic [7:0]        reg_fore;
	logic [7:0]        reg_back;
	screen_view_t      views_due [$];

	function automatic int cols_in_use();
		if (reg_cols == 0) return 1;
		if (reg_cols > MAX_COLUMNS) return MAX_COLUMNS;
		return reg_cols;
	endfunction

	function automatic int rows_in_use();
		if (reg_rows == 0) return 1;
		if (reg_rows > MAX_ROWS) return MAX_ROWS;
		return reg_rows;
	endfunction

	function automatic int at(int c, int r);
		return r * MAX_COLUMNS + c;
	endfunction

	function automatic logic [CELL_W-1:0] blank();
		return {reg_back, reg_fore, SPACE_CODE};
	endfunction

	// Shift the screen so that the cursor lands on its nearest edge cell.
	task automatic scroll_cursor_into_view();
		int cols;
		int rows;
		int n;
		cols = cols_in_use();
		rows = rows_in_use();
		if (ccol < 0) begin
			n = (-ccol > cols) ? cols : -ccol;
			for (int r = 0; r < rows; r++) begin
				for (int c = cols - 1; c >= n; c--) screen_mem[at(c, r)] = screen_mem[at(c - n, r)];
				for (int c = 0; c < n; c++) screen_mem[at(c, r)] = blank();
			end
			ccol = 0;
		end
		if (ccol >= cols) begin
			n = (ccol - cols + 1 > cols) ? cols : ccol - cols + 1;
			for (int r = 0; r < rows; r++) begin
				for (int c = 0; c < cols - n; c++) screen_mem[at(c, r)] = screen_mem[at(c + n, r)];
				for (int c = cols - n; c < cols; c++) screen_mem[at(c, r)] = blank();
			end
			ccol = cols - 1;
		end
		if (crow < 0) begin
			n = (-crow > rows) ? rows : -crow;
			for (int r = rows - 1; r >= n; r--)
				for (int c = 0; c < cols; c++) screen_mem[at(c, r)] = screen_mem[at(c, r - n)];
			for (int r = 0; r < n; r++)
				for (int c = 0; c < cols; c++) screen_mem[at(c, r)] = blank();
			crow = 0;
		end
		if (crow >= rows) begin
			n = (crow - rows + 1 > rows) ? rows : crow - rows + 1;
			for (int r = 0; r < rows - n; r++)
				for (int c = 0; c < cols; c++) screen_mem[at(c, r)] = screen_mem[at(c, r + n)];
			for (int r = rows - n; r < rows; r++)
				for (int c = 0; c < cols; c++) screen_mem[at(c, r)] = blank();
			crow = rows - 1;
		end
	endtask

	function automatic logic [CELL_W-1:0] cell_or_zero(int c, int r);
		if (c < 0 || r < 0 || c >= cols_in_use() || r >= rows_in_use()) return '0;
		return screen_mem[at(c, r)];
	endfunction

	// Run one command on the local screen copy and return what the block must report.
	task automatic run_command(input logic [3:0] code, input logic [7:0] ch,
			input logic [IPOS_W-1:0] pc_bits, input logic [IPOS_W-1:0] pr_bits,
			output screen_view_t view);
		int cols;
		int rows;
		int pc;
		int pr;
		logic [CELL_W-1:0] shown;
		cols = cols_in_use();
		rows = rows_in_use();
		pc = $signed(pc_bits);
		pr = $signed(pr_bits);
		if (code <= OP_BACKSPACE) scroll_cursor_into_view();
		case (code)
			OP_WRITE: begin
				screen_mem[at(ccol, crow)] = {reg_back, reg_fore, ch};
				ccol++;
				if (ccol >= cols) begin
					ccol = 0;
					crow++;
				end
			end
			OP_LEFT: begin
				if (ccol > 0) ccol--;
				else if (crow > 0) begin
					crow--;
					ccol = cols - 1;
				end
			end
			OP_RIGHT: begin
				if (ccol < cols - 1) ccol++;
				else if (crow < rows - 1) begin
					crow++;
					ccol = 0;
				end
			end
			OP_DOWN: crow++;
			OP_UP: if (crow > 0) crow--;
			OP_HOME: begin
				ccol = 0;
				crow = 0;
			end
			OP_LINESTART: ccol = 0;
			OP_BACKSPACE: begin
				if (ccol > 0) begin
					ccol--;
					screen_mem[at(ccol, crow)] = blank();
				end else if (crow > 0) begin
					crow--;
					ccol = cols - 1;
					screen_mem[at(ccol, crow)] = blank();
				end
			end
			OP_CLEAR: begin
				for (int r = 0; r < rows; r++)
					for (int c = 0; c < cols; c++) screen_mem[at(c, r)] = blank();
				ccol = 0;
				crow = 0;
			end
			OP_SETPOS: begin
				ccol = pc;
				crow = pr;
			end
			default: ;
		endcase
		shown = (code == OP_READ) ? cell_or_zero(pc, pr) : cell_or_zero(ccol, crow);
		view.ch   = shown[7:0];
		view.fore = shown[15:8];
		view.back = shown[23:16];
		view.col  = ccol[POS_W-1:0];
		view.row  = crow[POS_W-1:0];
	endtask

	task automatic report(string what, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		screen_view_t view;
		if (!arst_n) begin
			foreach (screen_mem[i]) screen_mem[i] = '0;
			ccol = 0;
			crow = 0;
			reg_cols = COLUMNS_RESET;
			reg_rows = ROWS_RESET;
			reg_fore = FORE_RESET;
			reg_back = BACK_RESET;
			views_due.delete();
			errors = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_COLUMNS: reg_cols = cfg_data;
					REG_ROWS:    reg_rows = cfg_data[6:0];
					REG_FORE:    reg_fore = cfg_data;
					REG_BACK:    reg_back = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				run_command(op, char_code, pos_column, pos_row, view);
				views_due.push_back(view);
			end
			// Compare each result with the oldest prediction.
			if (out_valid && out_ready) begin
				if (views_due.size() == 0) begin
					$display("%0t: result with none expected: char %0h cursor %0h,%0h", $time,
						cell_char, cursor_column, cursor_row);
					errors++;
				end else begin
					view = views_due.pop_front();
					if (cell_char != view.ch) report("cell_char", view.ch, cell_char);
					if (cell_fore != view.fore) report("cell_fore", view.fore, cell_fore);
					if (cell_back != view.back) report("cell_back", view.back, cell_back);
					if (cursor_column != view.col) report("cursor_column", view.col, cursor_column);
					if (cursor_row != view.row) report("cursor_row", view.row, cursor_row);
				end
			end
		end
		pending = views_due.size();
	end

endmodule

@@ verif/tb_top.sv @@
module tb_top import tcs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 10000000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [3:0]        op = '0;
	logic [7:0]        char_code = '0;
	logic [IPOS_W-1:0] pos_column = '0;
	logic [IPOS_W-1:0] pos_row = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        cell_char;
	logic [7:0]        cell_fore;
	logic [7:0]        cell_back;
	logic [POS_W-1:0]  cursor_column;
	logic [POS_W-1:0]  cursor_row;
	logic              cfg_wr_en = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [7:0]        cfg_data = '0;
	int                errors;
	int                pending;
	int                cycles = 0;
	int                hold_asks = 0;
	bit                quiet = 1'b0;
	int                cur_cols = 80;
	int                cur_rows = 30;

	text_cell_cursor_scroll_engine_core dut (.*);
	tb_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
	initial begin
		int stall_left;
		int holds_done;
		stall_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				stall_left = 400;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one request and hold it until taken, then leave a random gap.
	task automatic issue_cmd(logic [3:0] code, logic [7:0] ch, int pc, int pr);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		op <= code;
		char_code <= ch;
		pos_column <= pc[IPOS_W-1:0];
		pos_row <= pr[IPOS_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// Registers are only written once the screen has answered every request.
	task automatic set_screen(int cols, int rows, int fore, int back);
		logic [7:0] vals [4];
		logic [1:0] idx [4];
		drain_results();
		vals = '{cols[7:0], rows[7:0], fore[7:0], back[7:0]};
		idx = '{REG_COLUMNS, REG_ROWS, REG_FORE, REG_BACK};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_cols = (cols == 0) ? 1 : (cols > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : cols);
		cur_rows = (rows == 0) ? 1 : (rows > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows);
	endtask

	// Positions mostly around the screen edges, sometimes anywhere in the field.
	function automatic int near_pos(int span);
		if ($urandom_range(0, 4) == 0) return $urandom_range(0, 511) - 256;
		return $urandom_range(0, span + 6) - 3;
	endfunction

	task automatic random_cmd();
		int roll;
		logic [3:0] code;
		roll = $urandom_range(0, 99);
		if (roll < 30) code = OP_WRITE;
		else if (roll < 85) code = 4'($urandom_range(OP_LEFT, OP_READ));
		else if (roll < 95) code = OP_SETPOS;
		else code = 4'($urandom_range(11, 15));
		issue_cmd(code, 8'($urandom_range(0, 255)), near_pos(cur_cols), near_pos(cur_rows));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: edges of the fields and every command at the reset geometry.
		issue_cmd(OP_WRITE, 8'h41, 0, 0);
		issue_cmd(OP_WRITE, 8'hFF, 0, 0);
		issue_cmd(OP_WRITE, 8'h00, 0, 0);
		issue_cmd(OP_HOME, 0, 0, 0);
		issue_cmd(OP_LEFT, 0, 0, 0);
		issue_cmd(OP_BACKSPACE, 0, 0, 0);
		issue_cmd(OP_RIGHT, 0, 0, 0);
		issue_cmd(OP_SETPOS, 0, -256, -256);
		issue_cmd(OP_WRITE, 8'h5A, 0, 0);
		issue_cmd(OP_SETPOS, 0, 255, 255);
		issue_cmd(OP_LEFT, 0, 0, 0);
		issue_cmd(OP_SETPOS, 0, 79, 29);
		issue_cmd(OP_RIGHT, 0, 0, 0);
		issue_cmd(OP_DOWN, 0, 0, 0);
		issue_cmd(OP_UP, 0, 0, 0);
		issue_cmd(OP_LINESTART, 0, 0, 0);
		issue_cmd(OP_READ, 0, 0, 0);
		issue_cmd(OP_READ, 0, -1, 5);
		issue_cmd(OP_READ, 0, 255, -256);
		issue_cmd(OP_READ, 0, 79, 29);
		issue_cmd(OP_CLEAR, 0, 0, 0);
		issue_cmd(4'd11, 0, 0, 0);
		issue_cmd(4'd15, 0, 0, 0);
		issue_cmd(OP_SETPOS, 0, -3, 2);
		issue_cmd(OP_BACKSPACE, 0, 0, 0);

		// Largest screen, then zero and oversize values that clamp.
		set_screen(128, 64, 255, 0);
		issue_cmd(OP_CLEAR, 0, 0, 0);
		issue_cmd(OP_WRITE, 8'h42, 0, 0);
		issue_cmd(OP_SETPOS, 0, 130, -2);
		issue_cmd(OP_WRITE, 8'h43, 0, 0);
		issue_cmd(OP_READ, 0, 127, 63);
		set_screen(0, 0, 0, 255);
		repeat (12) random_cmd();
		set_screen(255, 127, 85, 170);
		issue_cmd(OP_SETPOS, 0, 2, 70);
		issue_cmd(OP_READ, 0, 127, 63);
		issue_cmd(OP_UP, 0, 0, 0);

		// Random phases on small screens.
		for (int phase = 0; phase < 8; phase++) begin
			set_screen($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 255),
				$urandom_range(0, 255));
			quiet = (phase == 2);
			if (phase == 1) hold_asks++;
			for (int k = 0; k < 10; k++) begin
				if (phase == 4 && k == 5) drain_results();
				random_cmd();
			end
		end
		quiet = 1'b0;

		drain_results();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_front.sv
hw/rtl/tcs_queue.sv
hw/rtl/tcs_back.sv
hw/rtl/text_cell_cursor_scroll_engine_core.sv
verif/tb_checker.sv
verif/tb_top.sv
